// File: hdl/sthp_pkg.sv
// Shared types and constants for the sensor temperature, pressure and humidity compensation.
package sthp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Divider geometry: 64-bit dividend, divisor magnitude at most 2^30
    localparam int QUO_W = 64;
    localparam int DEN_W = 31;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [26:0] PRESS_MAX = 27'd134217727;
    localparam logic [55:0] PRESS_INT_MAX = 56'd200000;
    localparam logic [31:0] HUM_CAP = 32'd419430400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LO   = 3'd1,
        CFG_PRESS_HI   = 3'd2,
        CFG_PRESS_LAST = 3'd3,
        CFG_HUM        = 3'd4
    } cfg_idx_t;

    // Fields that ride along with the pressure word through the divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic [16:0]        hum;
        logic               neg;
        logic               inval;
    } div_side_t;

endpackage

// File: hdl/sthp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module sthp_divider import sthp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [QUO_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  div_side_t        in_side,
    output logic             out_vld,
    output logic [QUO_W-1:0] out_quo,
    output div_side_t        out_side
);

    logic             vld_reg  [DIV_STEPS];
    logic [QUO_W-1:0] num_reg  [DIV_STEPS];
    logic [DEN_W-1:0] rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0] den_reg  [DIV_STEPS];
    div_side_t        side_reg [DIV_STEPS];

    logic [QUO_W-1:0] num_next [DIV_STEPS];
    logic [DEN_W-1:0] rem_next [DIV_STEPS];

    always_comb
    begin
        logic [QUO_W-1:0] np;
        logic [DEN_W-1:0] rp;
        logic [DEN_W-1:0] dp;
        logic [DEN_W:0]   trial;
        logic             ge;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                np = in_num;
                rp = '0;
                dp = in_den;
            end
            else
            begin
                np = num_reg[i-1];
                rp = rem_reg[i-1];
                dp = den_reg[i-1];
            end
            trial = {rp, np[QUO_W-1]};
            ge = trial >= {1'b0, dp};
            // shift the next dividend bit in, subtract when the divisor fits
            rem_next[i] = ge ? DEN_W'(trial - {1'b0, dp}) : trial[DEN_W-1:0];
            num_next[i] = {np[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                num_reg[i] <= num_next[i];
                rem_reg[i] <= rem_next[i];
            end
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign out_quo  = num_reg[DIV_STEPS-1];
    assign out_side = side_reg[DIV_STEPS-1];

endmodule

// File: hdl/sensor_thp_compensation.sv
// Top level: pipelined integer compensation of temperature, pressure and humidity.
//
// Takes one raw temperature/pressure/humidity triple per clock and returns the compensated
// triple after 9 stages build the fine temperature, the pressure terms and the humidity
// polynomial, 64 stages form the pressure quotient magnitude one bit per stage, and 7
// stages finish the pressure and register the result. Throughput is one beat per cycle;
// a stall on the output holds the whole pipeline, and in_stall follows it in the same cycle.
// Calibration registers are read live by the stages that use them, so write them only while no beat is
// in flight.
module sensor_thp_compensation import sthp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [19:0]           temp_adc,
    input  logic [19:0]           press_adc,
    input  logic [15:0]           hum_adc,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    temp_centi_deg,
    output logic [26:0]           press_milli_pa,
    output logic                  press_invalid,
    output logic [16:0]           hum_q10
);

    // ---------------- calibration registers ----------------
    logic [47:0]        temp_calib_reg;
    logic [63:0]        press_calib_lo_reg;
    logic [63:0]        press_calib_hi_reg;
    logic signed [15:0] press_calib_last_reg;
    logic [63:0]        hum_calib_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg       <= '0;
            press_calib_lo_reg   <= '0;
            press_calib_hi_reg   <= '0;
            press_calib_last_reg <= '0;
            hum_calib_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TEMP:       temp_calib_reg       <= cfg_data[47:0];
                CFG_PRESS_LO:   press_calib_lo_reg   <= cfg_data;
                CFG_PRESS_HI:   press_calib_hi_reg   <= cfg_data;
                CFG_PRESS_LAST: press_calib_last_reg <= $signed(cfg_data[15:0]);
                CFG_HUM:        hum_calib_reg        <= cfg_data;
                default:        ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = $signed(temp_calib_reg[31:16]);
    assign t3 = $signed(temp_calib_reg[47:32]);
    assign p1 = press_calib_lo_reg[15:0];
    assign p2 = $signed(press_calib_lo_reg[31:16]);
    assign p3 = $signed(press_calib_lo_reg[47:32]);
    assign p4 = $signed(press_calib_lo_reg[63:48]);
    assign p5 = $signed(press_calib_hi_reg[15:0]);
    assign p6 = $signed(press_calib_hi_reg[31:16]);
    assign p7 = $signed(press_calib_hi_reg[47:32]);
    assign p8 = $signed(press_calib_hi_reg[63:48]);
    assign p9 = press_calib_last_reg;
    assign h1 = hum_calib_reg[7:0];
    assign h2 = $signed(hum_calib_reg[23:8]);
    assign h3 = hum_calib_reg[31:24];
    assign h4 = $signed(hum_calib_reg[43:32]);
    assign h5 = $signed(hum_calib_reg[55:44]);
    assign h6 = $signed(hum_calib_reg[63:56]);

    // ---------------- flow control ----------------
    logic       adv;
    logic       out_vld_reg;
    logic [8:0] fv_reg;
    logic [5:0] bv_reg;

    assign adv       = !(out_vld_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = out_vld_reg;

    // ---------------- stage 1: temperature products ----------------
    logic signed [17:0] s1_diff;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_tp_next, s1_sq;
    logic [31:0]        s1_dd_next;
    logic signed [33:0] s1_tp_reg;
    logic [31:0]        s1_dd_reg;
    logic [19:0]        s1_pa_reg;
    logic [15:0]        s1_ha_reg;

    always_comb
    begin
        s1_diff    = $signed({1'b0, temp_adc[19:3]}) - $signed({1'b0, t1, 1'b0});
        s1_tp_next = s1_diff * t2;
        s1_d       = $signed({1'b0, temp_adc[19:4]}) - $signed({1'b0, t1});
        s1_sq      = s1_d * s1_d;
        s1_dd_next = s1_sq[31:0];
    end

    // ---------------- stage 2 ----------------
    logic signed [22:0] s2_v1_next, s2_v1_reg;
    logic signed [36:0] s2_x_next, s2_x_reg;
    logic [19:0]        s2_pa_reg;
    logic [15:0]        s2_ha_reg;

    always_comb
    begin
        s2_v1_next = 23'(s1_tp_reg >>> 11);
        s2_x_next  = $signed({1'b0, s1_dd_reg[31:12]}) * t3;
    end

    // ---------------- stage 3: fine temperature ----------------
    logic signed [24:0] s3_tf_next, s3_tf_reg;
    logic [19:0]        s3_pa_reg;
    logic [15:0]        s3_ha_reg;

    assign s3_tf_next = 25'(s2_v1_reg) + 25'(s2_x_reg >>> 14);

    // ---------------- stage 4 ----------------
    logic signed [27:0] s4_tt;
    logic signed [19:0] s4_tts;
    logic signed [15:0] s4_t_next;
    logic signed [26:0] s4_pv1;
    logic signed [53:0] s4_sq_next, s4_sq_reg;
    logic signed [42:0] s4_m5_next, s4_m5_reg, s4_m2_next, s4_m2_reg;
    logic signed [25:0] s4_hv;
    logic signed [37:0] s4_h5v_full;
    logic signed [33:0] s4_vh6_full;
    logic signed [34:0] s4_vh3_full;
    logic signed [15:0] s4_t_reg;
    logic [19:0]        s4_pa_reg;
    logic [15:0]        s4_ha_reg;
    logic [31:0]        s4_h5v_reg, s4_vh6_reg, s4_vh3_reg;

    always_comb
    begin
        s4_tt  = 28'(s3_tf_reg) * 28'sd5 + 28'sd128;
        s4_tts = 20'(s4_tt >>> 8);
        if (s4_tts > 20'sd32767)
        begin
            s4_t_next = 16'sd32767;
        end
        else if (s4_tts < -20'sd32768)
        begin
            s4_t_next = -16'sd32768;
        end
        else
        begin
            s4_t_next = 16'(s4_tts);
        end
        s4_pv1      = 27'(s3_tf_reg) - 27'sd128000;
        s4_sq_next  = s4_pv1 * s4_pv1;
        s4_m5_next  = s4_pv1 * p5;
        s4_m2_next  = s4_pv1 * p2;
        s4_hv       = 26'(s3_tf_reg) - 26'sd76800;
        s4_h5v_full = s4_hv * h5;
        s4_vh6_full = s4_hv * h6;
        s4_vh3_full = s4_hv * $signed({1'b0, h3});
    end

    // ---------------- stage 5 ----------------
    logic signed [69:0] s5_a6_full, s5_a3_full;
    logic [31:0]        s5_ha14, s5_h4s, s5_a0;
    logic signed [16:0] s5_ha_next, s5_ha_reg;
    logic signed [21:0] s5_b1, s5_c;
    logic signed [43:0] s5_bf;
    logic [63:0]        s5_a6_reg, s5_a3_reg;
    logic signed [42:0] s5_m5_reg, s5_m2_reg;
    logic signed [15:0] s5_t_reg;
    logic [19:0]        s5_pa_reg;
    logic [31:0]        s5_hb_reg;

    always_comb
    begin
        s5_a6_full = s4_sq_reg * p6;
        s5_a3_full = s4_sq_reg * p3;
        s5_ha14    = {2'b00, s4_ha_reg, 14'd0};
        s5_h4s     = {h4, 20'd0};
        s5_a0      = s5_ha14 - s5_h4s - s4_h5v_reg + 32'd16384;
        s5_ha_next = 17'($signed(s5_a0) >>> 15);
        s5_b1      = 22'($signed(s4_vh6_reg) >>> 10);
        s5_c       = 22'($signed(s4_vh3_reg) >>> 11) + 22'sd32768;
        s5_bf      = s5_b1 * s5_c;
    end

    // ---------------- stage 6 ----------------
    logic [63:0]        s6_v2_next, s6_s_next, s6_v2_reg, s6_s_reg;
    logic signed [22:0] s6_b2;
    logic signed [38:0] s6_bh2_full;
    logic signed [15:0] s6_t_reg;
    logic [19:0]        s6_pa_reg;
    logic signed [16:0] s6_ha_reg;
    logic [31:0]        s6_bh2_reg;

    always_comb
    begin
        s6_v2_next = s5_a6_reg + ({{21{s5_m5_reg[42]}}, s5_m5_reg} << 17)
                   + {{13{p4[15]}}, p4, 35'd0};
        s6_s_next  = {{8{s5_a3_reg[63]}}, s5_a3_reg[63:8]}
                   + {{9{s5_m2_reg[42]}}, s5_m2_reg, 12'd0}
                   + 64'h0000_8000_0000_0000;
        s6_b2       = 23'($signed(s5_hb_reg) >>> 10) + 23'sd2097152;
        s6_bh2_full = s6_b2 * h2;
    end

    // ---------------- stage 7 ----------------
    logic [79:0]        s7_prod_full;
    logic [20:0]        s7_pp;
    logic [63:0]        s7_np_next, s7_prod_reg, s7_np_reg;
    logic signed [17:0] s7_b3;
    logic signed [34:0] s7_hv2_full;
    logic signed [15:0] s7_t_reg;
    logic [31:0]        s7_hv2_reg;

    always_comb
    begin
        s7_prod_full = s6_s_reg * p1;
        s7_pp        = 21'd1048576 - {1'b0, s6_pa_reg};
        s7_np_next   = {12'd0, s7_pp, 31'd0} - s6_v2_reg;
        s7_b3        = 18'($signed(s6_bh2_reg + 32'd8192) >>> 14);
        s7_hv2_full  = s6_ha_reg * s7_b3;
    end

    // ---------------- stage 8 ----------------
    logic [75:0]        s8_num_full;
    logic signed [16:0] s8_d;
    logic signed [33:0] s8_dd_full;
    logic signed [30:0] s8_den_reg;
    logic [63:0]        s8_num_reg;
    logic signed [15:0] s8_t_reg;
    logic [31:0]        s8_hv2_reg, s8_dd_reg;

    always_comb
    begin
        s8_num_full = s7_np_reg * 12'd3125;
        s8_d        = 17'($signed(s7_hv2_reg) >>> 15);
        s8_dd_full  = s8_d * s8_d;
    end

    // ---------------- stage 9: magnitudes for the divider ----------------
    logic [63:0]        s9_un_next, s9_un_reg;
    logic [30:0]        s9_ud_next, s9_ud_reg;
    logic signed [24:0] s9_d2;
    logic signed [33:0] s9_dh1_full;
    logic               s9_neg_reg, s9_inval_reg;
    logic signed [15:0] s9_t_reg;
    logic [31:0]        s9_hv2_reg, s9_dh1_reg;

    always_comb
    begin
        s9_un_next  = s8_num_reg[63] ? 64'd0 - s8_num_reg : s8_num_reg;
        s9_ud_next  = s8_den_reg[30] ? 31'd0 - s8_den_reg : s8_den_reg;
        s9_d2       = 25'($signed(s8_dd_reg) >>> 7);
        s9_dh1_full = s9_d2 * $signed({1'b0, h1});
    end

    // finish humidity on its way into the divider
    logic [31:0] hm_dh1s, hm_v, hm_cl;
    div_side_t   dv_side;

    always_comb
    begin
        hm_dh1s = 32'($signed(s9_dh1_reg) >>> 4);
        hm_v    = s9_hv2_reg - hm_dh1s;
        if (hm_v[31])
        begin
            hm_cl = '0;
        end
        else if (hm_v > HUM_CAP)
        begin
            hm_cl = HUM_CAP;
        end
        else
        begin
            hm_cl = hm_v;
        end
        dv_side.temp  = s9_t_reg;
        dv_side.hum   = hm_cl[28:12];
        dv_side.neg   = s9_neg_reg;
        dv_side.inval = s9_inval_reg;
    end

    // ---------------- front pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (adv)
        begin
            fv_reg <= {fv_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tp_reg    <= s1_tp_next;
            s1_dd_reg    <= s1_dd_next;
            s1_pa_reg    <= press_adc;
            s1_ha_reg    <= hum_adc;
            s2_v1_reg    <= s2_v1_next;
            s2_x_reg     <= s2_x_next;
            s2_pa_reg    <= s1_pa_reg;
            s2_ha_reg    <= s1_ha_reg;
            s3_tf_reg    <= s3_tf_next;
            s3_pa_reg    <= s2_pa_reg;
            s3_ha_reg    <= s2_ha_reg;
            s4_t_reg     <= s4_t_next;
            s4_sq_reg    <= s4_sq_next;
            s4_m5_reg    <= s4_m5_next;
            s4_m2_reg    <= s4_m2_next;
            s4_pa_reg    <= s3_pa_reg;
            s4_ha_reg    <= s3_ha_reg;
            s4_h5v_reg   <= s4_h5v_full[31:0];
            s4_vh6_reg   <= s4_vh6_full[31:0];
            s4_vh3_reg   <= s4_vh3_full[31:0];
            s5_a6_reg    <= s5_a6_full[63:0];
            s5_a3_reg    <= s5_a3_full[63:0];
            s5_m5_reg    <= s4_m5_reg;
            s5_m2_reg    <= s4_m2_reg;
            s5_t_reg     <= s4_t_reg;
            s5_pa_reg    <= s4_pa_reg;
            s5_ha_reg    <= s5_ha_next;
            s5_hb_reg    <= s5_bf[31:0];
            s6_v2_reg    <= s6_v2_next;
            s6_s_reg     <= s6_s_next;
            s6_t_reg     <= s5_t_reg;
            s6_pa_reg    <= s5_pa_reg;
            s6_ha_reg    <= s5_ha_reg;
            s6_bh2_reg   <= s6_bh2_full[31:0];
            s7_prod_reg  <= s7_prod_full[63:0];
            s7_np_reg    <= s7_np_next;
            s7_t_reg     <= s6_t_reg;
            s7_hv2_reg   <= s7_hv2_full[31:0];
            s8_den_reg   <= $signed(s7_prod_reg[63:33]);
            s8_num_reg   <= s8_num_full[63:0];
            s8_t_reg     <= s7_t_reg;
            s8_hv2_reg   <= s7_hv2_reg;
            s8_dd_reg    <= s8_dd_full[31:0];
            s9_un_reg    <= s9_un_next;
            s9_ud_reg    <= s9_ud_next;
            s9_neg_reg   <= s8_num_reg[63] ^ s8_den_reg[30];
            s9_inval_reg <= (s8_den_reg == '0);
            s9_t_reg     <= s8_t_reg;
            s9_hv2_reg   <= s8_hv2_reg;
            s9_dh1_reg   <= s9_dh1_full[31:0];
        end
    end

    // ---------------- divider ----------------
    logic             dq_vld;
    logic [QUO_W-1:0] dq_quo;
    div_side_t        dq_side;

    sthp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (fv_reg[8]),
        .in_num   (s9_un_reg),
        .in_den   (s9_ud_reg),
        .in_side  (dv_side),
        .out_vld  (dq_vld),
        .out_quo  (dq_quo),
        .out_side (dq_side)
    );

    // ---------------- back stages: pressure correction ----------------
    logic [63:0]        q1_q_next, q1_q_reg;
    logic signed [50:0] q2_x;
    logic signed [66:0] q2_m9_full;
    logic signed [79:0] q2_m8_full;
    logic [63:0]        q2_x_reg, q2_m9_reg, q2_m8_reg, q2_q_reg;
    logic [63:0]        q3_pl_next, q3_pl_reg, q3_q_reg, q3_m8_reg;
    logic [31:0]        q3_c_next, q3_c_reg;
    logic [63:0]        q4_m9x_next, q4_m9x_reg, q4_q_reg, q4_m8_reg;
    logic [63:0]        q5_s_next, q5_s_reg;
    logic [63:0]        q6_pf_next, q6_pf_reg;
    div_side_t          q1_side_reg, q2_side_reg, q3_side_reg, q4_side_reg;
    div_side_t          q5_side_reg, q6_side_reg;

    always_comb
    begin
        q1_q_next   = dq_side.neg ? 64'd0 - dq_quo : dq_quo;
        q2_x        = 51'($signed(q1_q_reg) >>> 13);
        q2_m9_full  = p9 * q2_x;
        q2_m8_full  = p8 * $signed(q1_q_reg);
        // low 64 bits of the 64x64 product from three 32x32 partials
        q3_pl_next  = q2_m9_reg[31:0] * q2_x_reg[31:0];
        q3_c_next   = 32'(q2_m9_reg[63:32] * q2_x_reg[31:0])
                    + 32'(q2_m9_reg[31:0] * q2_x_reg[63:32]);
        q4_m9x_next = q3_pl_reg + {q3_c_reg, 32'd0};
        q5_s_next   = q4_q_reg + {{25{q4_m9x_reg[63]}}, q4_m9x_reg[63:25]}
                    + {{19{q4_m8_reg[63]}}, q4_m8_reg[63:19]};
        q6_pf_next  = {{8{q5_s_reg[63]}}, q5_s_reg[63:8]} + {{44{p7[15]}}, p7, 4'd0};
    end

    // scale Q56.8 pascal to milli-pascal and saturate, forcing zero when negative or invalid
    logic [55:0] op_int;
    logic [14:0] op_frac;
    logic [27:0] op_m;
    logic [26:0] op_press;

    always_comb
    begin
        op_int  = q6_pf_reg[63:8];
        op_frac = ({7'd0, q6_pf_reg[7:0]} * 15'd125) >> 5;
        op_m    = 28'(op_int[17:0]) * 28'd1000 + 28'(op_frac);
        if (q6_side_reg.inval || q6_pf_reg[63])
        begin
            op_press = '0;
        end
        else if (op_int > PRESS_INT_MAX || op_m > 28'(PRESS_MAX))
        begin
            op_press = PRESS_MAX;
        end
        else
        begin
            op_press = op_m[26:0];
        end
    end

    logic signed [15:0] temp_out_reg;
    logic [26:0]        press_out_reg;
    logic               inval_out_reg;
    logic [16:0]        hum_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg      <= {bv_reg[4:0], dq_vld};
            out_vld_reg <= bv_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_q_reg      <= q1_q_next;
            q1_side_reg   <= dq_side;
            q2_x_reg      <= {{13{q2_x[50]}}, q2_x};
            q2_m9_reg     <= q2_m9_full[63:0];
            q2_m8_reg     <= q2_m8_full[63:0];
            q2_q_reg      <= q1_q_reg;
            q2_side_reg   <= q1_side_reg;
            q3_pl_reg     <= q3_pl_next;
            q3_c_reg      <= q3_c_next;
            q3_q_reg      <= q2_q_reg;
            q3_m8_reg     <= q2_m8_reg;
            q3_side_reg   <= q2_side_reg;
            q4_m9x_reg    <= q4_m9x_next;
            q4_q_reg      <= q3_q_reg;
            q4_m8_reg     <= q3_m8_reg;
            q4_side_reg   <= q3_side_reg;
            q5_s_reg      <= q5_s_next;
            q5_side_reg   <= q4_side_reg;
            q6_pf_reg     <= q6_pf_next;
            q6_side_reg   <= q5_side_reg;
            temp_out_reg  <= q6_side_reg.temp;
            press_out_reg <= op_press;
            inval_out_reg <= q6_side_reg.inval;
            hum_out_reg   <= q6_side_reg.hum;
        end
    end

    assign temp_centi_deg = temp_out_reg;
    assign press_milli_pa = press_out_reg;
    assign press_invalid  = inval_out_reg;
    assign hum_q10        = hum_out_reg;

    // ---------------- assertions ----------------
    a_inval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_invalid |-> press_milli_pa == '0)
        else $error("pressure not forced to zero on invalid divisor");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hum_q10 <= 17'd102400)
        else $error("humidity above full scale");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> fv_reg[0])
        else $error("accepted beat lost at pipeline entry");

endmodule

// File: bench/tb_sensor_thp_compensation.sv
// Self-checking testbench for the temperature, pressure and humidity compensation pipeline.
module tb_sensor_thp_compensation import sthp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 80;
    localparam int STUCK_LIMIT = 4000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [19:0] temp_adc;
        logic [19:0] press_adc;
        logic [15:0] hum_adc;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [26:0]        press;
        logic               inval;
        logic [16:0]        hum;
    } comp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [19:0]           temp_adc;
    logic [19:0]           press_adc;
    logic [15:0]           hum_adc;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [15:0]    temp_centi_deg;
    logic [26:0]           press_milli_pa;
    logic                  press_invalid;
    logic [16:0]           hum_q10;

    sensor_thp_compensation uut (.*);

    // calibration shadow, written alongside the block's registers
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_press_last;
    logic [63:0] cal_hum;

    sample_t pending_samples[$];
    comp_t   expected_readings[$];
    int      sender_idle_pct;
    int      receiver_idle_pct;
    int      hold_left;
    int      mismatches;
    int      stuck_cycles;
    logic    in_beat;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint div_trunc(longint n, longint d);
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        return ((n < 0) != (d < 0)) ? longint'(-q) : longint'(q);
    endfunction

    function automatic comp_t compensate(sample_t s);
        longint ta, pa, t1, t2, t3;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint d, tf, t, v1, v2, p, m;
        int     h1, h2, h3, h4, h5, h6, hv, a, b, hd;
        comp_t  r;
        ta = longint'(s.temp_adc);
        pa = longint'(s.press_adc);
        t1 = longint'(cal_temp[15:0]);
        t2 = longint'($signed(cal_temp[31:16]));
        t3 = longint'($signed(cal_temp[47:32]));
        p1 = longint'(cal_press_lo[15:0]);
        p2 = longint'($signed(cal_press_lo[31:16]));
        p3 = longint'($signed(cal_press_lo[47:32]));
        p4 = longint'($signed(cal_press_lo[63:48]));
        p5 = longint'($signed(cal_press_hi[15:0]));
        p6 = longint'($signed(cal_press_hi[31:16]));
        p7 = longint'($signed(cal_press_hi[47:32]));
        p8 = longint'($signed(cal_press_hi[63:48]));
        p9 = longint'($signed(cal_press_last));
        h1 = int'(cal_hum[7:0]);
        h2 = int'($signed(cal_hum[23:8]));
        h3 = int'(cal_hum[31:24]);
        h4 = int'($signed(cal_hum[43:32]));
        h5 = int'($signed(cal_hum[55:44]));
        h6 = int'($signed(cal_hum[63:56]));

        // fine temperature, exact
        v1 = (((ta >>> 3) - t1 * 2) * t2) >>> 11;
        d = (ta >>> 4) - t1;
        v2 = (((d * d) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        t = (tf * 5 + 128) >>> 8;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        r.temp = t[15:0];

        // pressure, wraps at 64 bits
        r.press = '0;
        r.inval = 1'b0;
        v1 = tf - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = (((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12));
        v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0)
            r.inval = 1'b1;
        else
        begin
            p = 1048576 - pa;
            p = div_trunc(((p <<< 31) - v2) * 3125, v1);
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            if (p < 0)
                r.press = '0;
            else if ((p >>> 8) > 200000)
                r.press = PRESS_MAX;
            else
            begin
                m = (p >>> 8) * 1000 + ((p & 255) * 390625) / 100000;
                r.press = (m > 134217727) ? PRESS_MAX : m[26:0];
            end
        end

        // humidity, wraps at 32 bits
        hv = int'(tf - 76800);
        a = (int'(s.hum_adc) <<< 14) - h4 * 1048576 - h5 * hv;
        a = (a + 16384) >>> 15;
        b = (hv * h6) >>> 10;
        b = b * (((hv * h3) >>> 11) + 32768);
        b = (b >>> 10) + 2097152;
        b = (b * h2 + 8192) >>> 14;
        hv = a * b;
        hd = hv >>> 15;
        hd = (hd * hd) >>> 7;
        hv = hv - ((hd * h1) >>> 4);
        if (hv < 0)
            hv = 0;
        if (hv > 419430400)
            hv = 419430400;
        r.hum = hv[28:12];
        return r;
    endfunction

    // input side: accept on the rising edge, present the next beat on the falling edge
    always @(posedge clk)
    begin
        in_beat <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_readings.push_back(compensate('{temp_adc, press_adc, hum_adc}));
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_beat)
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                {temp_adc, press_adc, hum_adc} <= pending_samples.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        comp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat: temp %0d press %0d inval %0b hum %0d",
                             temp_centi_deg, press_milli_pa, press_invalid, hum_q10);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (want.temp !== temp_centi_deg || want.press !== press_milli_pa ||
                    want.inval !== press_invalid || want.hum !== hum_q10)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: exp temp %0d press %0d inval %0b hum %0d,",
                                  " got temp %0d press %0d inval %0b hum %0d"},
                                 want.temp, want.press, want.inval, want.hum,
                                 temp_centi_deg, press_milli_pa, press_invalid, hum_q10);
                end
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_samples.size() == 0 && !in_valid && expected_readings.size() == 0);
        repeat (PIPE_DEPTH + 10) @(negedge clk);
    endtask

    task automatic write_calib(cfg_idx_t idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_TEMP:       cal_temp = value[47:0];
            CFG_PRESS_LO:   cal_press_lo = value;
            CFG_PRESS_HI:   cal_press_hi = value;
            CFG_PRESS_LAST: cal_press_last = value[15:0];
            CFG_HUM:        cal_hum = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_calib(logic [47:0] tc, logic [63:0] plo, logic [63:0] phi,
                              logic [15:0] plast, logic [63:0] hc);
        drain();
        write_calib(CFG_TEMP, {16'h0, tc});
        write_calib(CFG_PRESS_LO, plo);
        write_calib(CFG_PRESS_HI, phi);
        write_calib(CFG_PRESS_LAST, {{48{plast[15]}}, plast});
        write_calib(CFG_HUM, hc);
        cfg_we <= 1'b0;
    endtask

    task automatic load_typical();
        load_calib({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                   16'd6000,
                   {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
    endtask

    task automatic load_random();
        load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom), {$urandom, $urandom});
    endtask

    // mostly readings near a real sensor's range, with some full-range noise
    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                pending_samples.push_back('{20'($urandom), 20'($urandom), 16'($urandom)});
            else
                pending_samples.push_back('{20'($urandom_range(560000, 380000)),
                                            20'($urandom_range(420000, 250000)),
                                            16'($urandom_range(40000, 20000))});
        end
    endtask

    task automatic queue_directed();
        pending_samples.push_back('{20'h0, 20'h0, 16'h0});
        pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        pending_samples.push_back('{20'h0, 20'hFFFFF, 16'h0});
        pending_samples.push_back('{20'hFFFFF, 20'h0, 16'hFFFF});
        pending_samples.push_back('{20'd519888, 20'd415148, 16'd30000});
        pending_samples.push_back('{20'h80000, 20'h80000, 16'h8000});
        pending_samples.push_back('{20'h7FFFF, 20'h7FFFF, 16'h7FFF});
        pending_samples.push_back('{20'h55555, 20'hAAAAA, 16'h5555});
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_data = '0;
        in_valid = 1'b0;
        temp_adc = '0;
        press_adc = '0;
        hum_adc = '0;
        out_stall = 1'b0;
        hold_left = 0;
        mismatches = 0;
        stuck_cycles = 0;
        in_beat = 1'b0;
        cal_temp = '0;
        cal_press_lo = '0;
        cal_press_hi = '0;
        cal_press_last = '0;
        cal_hum = '0;
        sender_idle_pct = 20;
        receiver_idle_pct = 49;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed samples: first under reset calibration (zero divisor), then typical, all-ones and 0x8000 calibration
        queue_directed();
        load_typical();
        queue_directed();
        load_calib('1, '1, '1, 16'hFFFF, '1);
        queue_directed();
        load_calib({16'h8000, 16'h8000, 16'h0}, {16'h8000, 16'h8000, 16'h8000, 16'h0},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000,
                   {8'h80, 12'h800, 12'h800, 8'h0, 16'h8000, 8'h0});
        queue_directed();

        load_typical();
        queue_random(300);
        load_random();
        queue_random(150);

        sender_idle_pct = 49;
        receiver_idle_pct = 20;
        load_typical();
        queue_random(200);
        hold_left = LONG_HOLD;
        queue_random(150);
        load_random();
        queue_random(150);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        load_typical();
        queue_random(300);
        drain();
        queue_random(250);
        hold_left = LONG_HOLD;
        load_random();
        queue_random(200);

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
hdl/sthp_pkg.sv
hdl/sthp_divider.sv
hdl/sensor_thp_compensation.sv
bench/tb_sensor_thp_compensation.sv
